// File: hw/rtl/sorted_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check clocked on clk_i, off while rst_ni is low
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check clocked on clk_i, also during reset
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizes
  localparam int unsigned DefCapacity    = 16;
  localparam int unsigned DefPayloadBits = 32;

  // fixed port widths
  localparam int unsigned PayloadW = 32;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned CountW   = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds, inserts, or shifts an entry
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned StoreW = DefPayloadBits
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    occ_i,
  input  logic signed [PrioW-1:0] new_prio_i,
  input  logic [StoreW-1:0]       new_payload_i,
  input  logic                    upper_keep_i,
  input  logic signed [PrioW-1:0] upper_prio_i,
  input  logic [StoreW-1:0]       upper_payload_i,
  input  logic signed [PrioW-1:0] lower_prio_i,
  input  logic [StoreW-1:0]       lower_payload_i,
  output logic                    keep_o,
  output logic signed [PrioW-1:0] prio_o,
  output logic [StoreW-1:0]       payload_o
);

  logic signed [PrioW-1:0] prio_q, prio_d;
  logic [StoreW-1:0]       payload_q, payload_d;

  // entry stays when it strictly outranks the new item
  assign keep_o = occ_i && (prio_q > new_prio_i);

  // next slot contents
  always_comb begin
    prio_d    = prio_q;
    payload_d = payload_q;
    if (ctrl_i.push) begin
      if (!keep_o) begin
        if (upper_keep_i) begin
          prio_d    = new_prio_i;
          payload_d = new_payload_i;
        end else begin
          prio_d    = upper_prio_i;
          payload_d = upper_payload_i;
        end
      end
    end else if (ctrl_i.pop) begin
      prio_d    = lower_prio_i;
      payload_d = lower_payload_i;
    end
  end

  // slot storage, no reset needed
  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

// File: hw/rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue kept sorted in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// command  in         start_i / busy_o     cmd_i, payload_i, prio_i
// result   out        done_o (one cycle)   head_payload_o, head_valid_o,
//                                          entry_count_o, status_o
//
// on every command all cells compare against the new item in
// parallel and load, hold or shift at the same edge; busy_o stays low
// the result strobes on done_o in the cycle after the command is taken
// reset clears the entry count and the result strobe; slot contents are
// left as they are
// the receiver cannot stall, so each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY     = DefCapacity,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              cmd_i,
  input  logic [PayloadW-1:0]     payload_i,
  input  logic signed [PrioW-1:0] prio_i,
  output logic                    done_o,
  output logic [PayloadW-1:0]     head_payload_o,
  output logic                    head_valid_o,
  output logic [CountW-1:0]       entry_count_o,
  output logic [1:0]              status_o
);

  `include "sorted_priority_queue_top_assert.svh"

  localparam int unsigned StoreW = (PAYLOAD_BITS < PayloadW) ? PAYLOAD_BITS : PayloadW;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapVal = CntW'(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  status_e         status_q, status_d;
  cell_ctrl_t      ctrl;
  logic            full, empty;
  logic            accept;

  logic                    cell_keep    [CAPACITY];
  logic signed [PrioW-1:0] cell_prio    [CAPACITY];
  logic [StoreW-1:0]       cell_payload [CAPACITY];
  logic [StoreW-1:0]       new_payload;

  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;
  assign full        = (count_q == CapVal);
  assign empty       = (count_q == '0);
  assign new_payload = payload_i[StoreW-1:0];

  // command decode
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_OK;
    if (accept) begin
      unique case (cmd_i)
        CMD_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // cell chain, slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    upper_keep;
    logic signed [PrioW-1:0] upper_prio, lower_prio;
    logic [StoreW-1:0]       upper_payload, lower_payload;

    if (i == 0) begin : g_first
      assign upper_keep    = 1'b1;
      assign upper_prio    = prio_i;
      assign upper_payload = new_payload;
    end else begin : g_mid
      assign upper_keep    = cell_keep[i-1];
      assign upper_prio    = cell_prio[i-1];
      assign upper_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign lower_prio    = cell_prio[i];
      assign lower_payload = cell_payload[i];
    end else begin : g_inner
      assign lower_prio    = cell_prio[i+1];
      assign lower_payload = cell_payload[i+1];
    end

    spq_cell #(
      .StoreW(StoreW)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (count_q > CntW'(i)),
      .new_prio_i     (prio_i),
      .new_payload_i  (new_payload),
      .upper_keep_i   (upper_keep),
      .upper_prio_i   (upper_prio),
      .upper_payload_i(upper_payload),
      .lower_prio_i   (lower_prio),
      .lower_payload_i(lower_payload),
      .keep_o         (cell_keep[i]),
      .prio_o         (cell_prio[i]),
      .payload_o      (cell_payload[i])
    );
  end

  // count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  // result view of the head
  assign done_o         = done_q;
  assign head_valid_o   = !empty;
  assign head_payload_o = empty ? '0 : PayloadW'(cell_payload[0]);
  assign entry_count_o  = CountW'(count_q);
  assign status_o       = status_q;

  // checks
  `SPQ_ASSERT(a_count_bound, count_q <= CapVal, "entry count above capacity")
  `SPQ_ASSERT(a_push_grows, ctrl.push |=> count_q == $past(count_q) + 1'b1, "push not counted")
  `SPQ_ASSERT(a_pop_shrinks, ctrl.pop |=> count_q == $past(count_q) - 1'b1, "pop not counted")
  `SPQ_ASSERT(a_done_follows, accept |=> done_o, "result strobe does not follow command")
  `SPQ_ASSERT(a_head_order, count_q >= CntW'(2) |-> cell_prio[0] >= cell_prio[1], "head outranked")
  `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o && count_q == '0, "reset state not clear")

endmodule
